// ----- rtl/dimmer_level_tracker_defines.svh -----
// Assertion macros used by the dimmer level tracker RTL.
`ifndef DIMMER_LEVEL_TRACKER_DEFINES_SVH
`define DIMMER_LEVEL_TRACKER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dlt_pkg.sv -----
// Types, codes and level conversion functions for the dimmer level tracker.
package dlt_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_ADVANCED_MODE        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HUNDRED_STEP_OUTPUTS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FAULT_CODE           = 2'd2;

  localparam logic [5:0] FAULT_CODE_RESET = 6'd19;

  localparam logic [1:0] KIND_COMMAND   = 2'd0;
  localparam logic [1:0] KIND_DIM_READ  = 2'd1;
  localparam logic [1:0] KIND_DIM_WRITE = 2'd2;

  localparam logic [5:0] CMD_OFF         = 6'd0;
  localparam logic [5:0] CMD_ON          = 6'd1;
  localparam logic [5:0] TIMED_ON_FIRST  = 6'd11;
  localparam logic [5:0] TIMED_ON_LAST   = 6'd18;
  localparam logic [5:0] TEN_STEP_LOW    = 6'd2;
  localparam logic [5:0] TEN_STEP_HIGH   = 6'd10;
  localparam logic [5:0] CMD_STEP_UP     = 6'd30;
  localparam logic [5:0] CMD_STEP_DOWN   = 6'd31;
  localparam logic [5:0] DIM_STATUS_CODE = 6'd1;

  localparam logic [6:0] LEVEL_MAX = 7'd100;
  localparam logic [7:0] STATUS_OFFSET = 8'd100;
  localparam logic [7:0] STATUS_TOP    = 8'd200;

  typedef struct packed {
    logic [1:0] frame_kind;
    logic [5:0] what_code;
    logic [1:0] arg_count;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
    logic       point_to_point;
  } dlt_in_t;

  typedef struct packed {
    logic       on_valid;
    logic       on_value;
    logic       ten_valid;
    logic [3:0] ten_level;
    logic       hundred_valid;
    logic [6:0] hundred_level;
    logic       speed_valid;
    logic [7:0] ramp_speed;
    logic       fault_seen;
    logic       start_query;
    logic       cancel_query;
  } dlt_out_t;

  typedef struct packed {
    logic       advanced_mode;
    logic       hundred_step_outputs;
    logic [5:0] fault_code;
  } dlt_cfg_t;

  typedef struct packed {
    logic       lamp_lit;
    logic [6:0] dim_level;
  } dlt_state_t;

  // Hundred-step level to ten-step level; zero stays zero.
  function automatic logic [3:0] hundred_to_ten(input logic [6:0] v);
    logic [3:0] t;
    if (v == 7'd0)       t = 4'd0;
    else if (v <= 7'd4)  t = 4'd2;
    else if (v <= 7'd15) t = 4'd3;
    else if (v <= 7'd25) t = 4'd4;
    else if (v <= 7'd35) t = 4'd5;
    else if (v <= 7'd45) t = 4'd6;
    else if (v <= 7'd53) t = 4'd7;
    else if (v <= 7'd67) t = 4'd8;
    else if (v <= 7'd85) t = 4'd9;
    else                 t = 4'd10;
    return t;
  endfunction

  // Ten-step level (2 to 10) to hundred-step level.
  function automatic logic [6:0] ten_to_hundred(input logic [3:0] t);
    logic [6:0] v;
    case (t)
      4'd2:    v = 7'd1;
      4'd3:    v = 7'd10;
      4'd4:    v = 7'd20;
      4'd5:    v = 7'd30;
      4'd6:    v = 7'd40;
      4'd7:    v = 7'd50;
      4'd8:    v = 7'd60;
      4'd9:    v = 7'd75;
      4'd10:   v = 7'd100;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/dimmer_level_tracker.sv -----
// Dimmer level tracker top level: frame register, update logic, result register.
//
//   channel   direction  handshake                  payload
//   frame     in         frame_valid/frame_ready    frame  (dlt_in_t)
//   result    out        result_valid/result_ready  result (dlt_out_t)
//   cfg       in         cfg_en                     cfg_addr, cfg_wdata
//
// One frame is taken per cycle while the frame register is free or can move on;
// a frame passes through the frame register and then the result register, and a
// stalled result holds it in the frame register.
// The light state is updated as a frame moves from the frame register into the
// result register, so the next frame in the frame register sees the new state.
// Reset clears the state and both valid flags and sets the configuration defaults.
// A stalled result holds the pipeline; an empty frame register still fills.
`include "dimmer_level_tracker_defines.svh"

module dimmer_level_tracker import dlt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   frame_valid,
  output logic                   frame_ready,
  input  dlt_in_t                frame,
  output logic                   result_valid,
  input  logic                   result_ready,
  output dlt_out_t               result,
  input  logic                   cfg_en,
  input  logic [CFG_INDEX_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  dlt_cfg_t   cfg;
  dlt_state_t state;
  dlt_state_t state_next;
  dlt_in_t    item;
  dlt_out_t   report;
  logic       item_valid;
  logic       advance;

  assign advance     = !result_valid || result_ready;
  assign frame_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.advanced_mode        <= 1'b0;
      cfg.hundred_step_outputs <= 1'b0;
      cfg.fault_code           <= FAULT_CODE_RESET;
    end else if (cfg_en) begin
      case (cfg_addr)
        REG_ADVANCED_MODE:        cfg.advanced_mode        <= cfg_wdata[0];
        REG_HUNDRED_STEP_OUTPUTS: cfg.hundred_step_outputs <= cfg_wdata[0];
        REG_FAULT_CODE:           cfg.fault_code           <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (frame_ready) begin
      item_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      item <= frame;
    end
  end

  dlt_update u_update (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .report     (report),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid    <= 1'b0;
      state.lamp_lit  <= 1'b0;
      state.dim_level <= 7'd0;
    end else if (advance) begin
      result_valid <= item_valid;
      if (item_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      result <= report;
    end
  end

  `DLT_ASSERT_NEXT(a_item_kept, item_valid && !advance, item_valid, "stalled frame dropped")
  `DLT_ASSERT_NOW(a_level_range, 1'b1, state.dim_level <= LEVEL_MAX, "stored level above 100")
  `DLT_ASSERT_NOW(a_query_excl, result_valid, !(result.start_query && result.cancel_query), "start and cancel")
  `DLT_ASSERT_NOW(a_ten_zero, result_valid && !result.ten_valid, result.ten_level == 4'd0, "stray level")

endmodule

// ----- rtl/dlt_update.sv -----
// Frame decode and state update: one frame in, one report and next state out.
module dlt_update import dlt_pkg::*; (
  input  dlt_cfg_t   cfg,
  input  dlt_state_t state,
  input  dlt_in_t    item,
  output dlt_out_t   report,
  output dlt_state_t state_next
);

  logic       adv;
  logic       isdim;
  logic       incdec;
  logic       is_inc;
  logic       is_onoff;
  logic       is_fixed;
  logic       is_level_cmd;
  logic [3:0] cur_ten;
  logic [3:0] step_ten;
  logic [8:0] inc_sum;
  logic [6:0] adv_lvl;
  logic [7:0] status_diff;
  logic [6:0] status_lvl;

  logic       on_v;
  logic       on_x;
  logic       ten_v;
  logic [3:0] ten_x;
  logic       hun_v;
  logic [6:0] hun_x;
  logic       spd_v;
  logic [7:0] spd_x;
  logic       fault;
  logic       start;
  logic       cancel;
  logic       lon;
  logic [6:0] lvl;

  assign adv      = cfg.advanced_mode | cfg.hundred_step_outputs;
  assign isdim    = (item.frame_kind == KIND_DIM_READ) || (item.frame_kind == KIND_DIM_WRITE);
  assign is_inc   = (item.what_code == CMD_STEP_UP);
  assign incdec   = is_inc || (item.what_code == CMD_STEP_DOWN);
  assign is_onoff = (item.frame_kind == KIND_COMMAND) &&
                    ((item.what_code == CMD_ON) || (item.what_code == CMD_OFF));
  assign is_fixed = (item.what_code >= TIMED_ON_FIRST) &&
                    (item.what_code <= TIMED_ON_LAST);
  assign is_level_cmd = (item.what_code >= TEN_STEP_LOW) &&
                        (item.what_code <= TEN_STEP_HIGH);

  // Increase and decrease only ever start from the stored level, since the
  // codes that change the level earlier in the frame exclude them.
  assign cur_ten = hundred_to_ten(state.dim_level);
  always_comb begin
    if (is_inc) begin
      if (cur_ten <= 4'd1)       step_ten = 4'd2;
      else if (cur_ten >= 4'd10) step_ten = 4'd10;
      else                       step_ten = cur_ten + 4'd1;
    end else begin
      if (cur_ten <= 4'd3) step_ten = 4'd2;
      else                 step_ten = cur_ten - 4'd1;
    end
  end

  assign inc_sum = {2'b00, state.dim_level} + {1'b0, item.arg_first};
  always_comb begin
    if (is_inc) begin
      if (inc_sum > {2'b00, LEVEL_MAX}) adv_lvl = LEVEL_MAX;
      else if (inc_sum == 9'd0)         adv_lvl = 7'd1;
      else                              adv_lvl = inc_sum[6:0];
    end else begin
      if (item.arg_first >= {1'b0, state.dim_level}) adv_lvl = 7'd1;
      else adv_lvl = state.dim_level - item.arg_first[6:0];
    end
  end

  assign status_diff = item.arg_first - STATUS_OFFSET;
  always_comb begin
    if (item.arg_first < STATUS_OFFSET)   status_lvl = 7'd0;
    else if (item.arg_first > STATUS_TOP) status_lvl = LEVEL_MAX;
    else                                  status_lvl = status_diff[6:0];
  end

  always_comb begin
    on_v   = 1'b0;
    on_x   = 1'b0;
    ten_v  = 1'b0;
    ten_x  = 4'd0;
    hun_v  = 1'b0;
    hun_x  = 7'd0;
    spd_v  = 1'b0;
    spd_x  = 8'd0;
    fault  = 1'b0;
    start  = 1'b0;
    cancel = 1'b0;
    lon    = state.lamp_lit;
    lvl    = state.dim_level;

    if (is_onoff && ((item.arg_count == 2'd0) || ((item.arg_count == 2'd1) && adv))) begin
      on_v = 1'b1;
      on_x = (item.what_code == CMD_ON);
    end
    if (is_fixed) begin
      on_v = 1'b1;
      on_x = 1'b1;
    end

    // Switching on with no known level starts the delayed level query,
    // unless the frame was addressed to this device alone.
    if (on_v) begin
      lon = on_x;
      if (lon && (lvl == 7'd0) && !item.point_to_point) start = 1'b1;
      else cancel = 1'b1;
      if (lon && (lvl != 7'd0)) begin
        ten_v = 1'b1;
        ten_x = hundred_to_ten(lvl);
      end
    end

    if (item.frame_kind == KIND_COMMAND) begin
      if (is_level_cmd) begin
        lvl   = ten_to_hundred(item.what_code[3:0]);
        on_v  = 1'b1;
        on_x  = 1'b1;
        ten_v = 1'b1;
        ten_x = hundred_to_ten(lvl);
      end else if (item.what_code == cfg.fault_code) begin
        fault = 1'b1;
      end
    end

    if (incdec && (item.arg_count == 2'd0)) begin
      if (lon) begin
        lvl   = ten_to_hundred(step_ten);
        ten_v = 1'b1;
        ten_x = step_ten;
      end else begin
        lon   = 1'b1;
        ten_v = 1'b1;
        ten_x = hundred_to_ten(lvl);
      end
      on_v = 1'b1;
      on_x = 1'b1;
    end

    if (incdec && (item.arg_count == 2'd2) && adv) begin
      if (lon) lvl = adv_lvl;
      else     lon = 1'b1;
      ten_v = 1'b1;
      ten_x = hundred_to_ten(lvl);
      on_v  = 1'b1;
      on_x  = 1'b1;
    end

    if ((item.what_code == DIM_STATUS_CODE) && isdim && adv) begin
      if (item.arg_first == STATUS_OFFSET) begin
        lon  = 1'b0;
        on_v = 1'b1;
        on_x = 1'b0;
      end else begin
        lvl   = status_lvl;
        lon   = 1'b1;
        on_v  = 1'b1;
        on_x  = 1'b1;
        ten_v = 1'b1;
        ten_x = hundred_to_ten(lvl);
      end
    end

    if (cfg.hundred_step_outputs) begin
      if (ten_v) begin
        hun_v = 1'b1;
        hun_x = lvl;
      end
      if (is_onoff && (item.arg_count == 2'd1)) begin
        on_v = 1'b1;
        on_x = (item.what_code == CMD_ON);
      end
      if ((item.what_code == DIM_STATUS_CODE) && (item.frame_kind == KIND_DIM_READ) && lon) begin
        spd_v = 1'b1;
        spd_x = item.arg_second;
      end
      if (incdec && (item.arg_count == 2'd2)) begin
        hun_v = 1'b1;
        hun_x = lvl;
      end
    end
  end

  assign report.on_valid      = on_v;
  assign report.on_value      = on_x;
  assign report.ten_valid     = ten_v;
  assign report.ten_level     = ten_x;
  assign report.hundred_valid = hun_v;
  assign report.hundred_level = hun_x;
  assign report.speed_valid   = spd_v;
  assign report.ramp_speed    = spd_x;
  assign report.fault_seen    = fault;
  assign report.start_query   = start;
  assign report.cancel_query  = cancel;

  assign state_next.lamp_lit  = lon;
  assign state_next.dim_level = lvl;

endmodule

// ----- dv/dimmer_level_tracker_tb.sv -----
// Self-checking testbench for the dimmer level tracker: directed and random frames.
module dimmer_level_tracker_tb import dlt_pkg::*; ();

  localparam logic [1:0] KIND_OTHER  = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int IN_W        = $bits(dlt_in_t);
  localparam int LONG_HOLD   = 120;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 110;

  logic                   clk;
  logic                   rst;
  logic                   frame_valid;
  logic                   frame_ready;
  dlt_in_t                frame;
  logic                   result_valid;
  logic                   result_ready;
  dlt_out_t               result;
  logic                   cfg_en;
  logic [CFG_INDEX_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // Shadow of the configuration and of the light state.
  bit         cfg_adv;
  bit         cfg_hso;
  logic [5:0] cfg_fault;
  bit         lamp_on;
  logic [6:0] lamp_level;

  dlt_out_t expected_results[$];
  int       mismatches;
  int       quiet_cycles;
  int       burst_left;
  bit       tx_steady;
  bit       rx_steady;
  int       hold_requests;

  dimmer_level_tracker DUT (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame        (frame),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_en       (cfg_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int ten_step_of(input int v);
    if (v == 0) return 0;
    if (v <= 4) return 2;
    if (v <= 15) return 3;
    if (v <= 25) return 4;
    if (v <= 35) return 5;
    if (v <= 45) return 6;
    if (v <= 53) return 7;
    if (v <= 67) return 8;
    if (v <= 85) return 9;
    return 10;
  endfunction

  function automatic int level_of_ten(input int t);
    case (t)
      2:       return 1;
      9:       return 75;
      10:      return 100;
      default: return (t - 2) * 10;
    endcase
  endfunction

  function automatic int clamp(input int v, input int lo, input int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Works out the report for one frame and moves the light state on.
  function automatic dlt_out_t track_frame(input dlt_in_t f);
    dlt_out_t r;
    bit       adv;
    bit       is_dim;
    bit       inc_dec;
    bit       on_off;
    int       lvl;
    int       cnt;
    int       a1;
    int       tens;
    r       = '0;
    cnt     = int'(f.arg_count);
    a1      = int'(f.arg_first);
    adv     = cfg_adv || cfg_hso;
    is_dim  = f.frame_kind == KIND_DIM_READ || f.frame_kind == KIND_DIM_WRITE;
    inc_dec = f.what_code == CMD_STEP_UP || f.what_code == CMD_STEP_DOWN;
    on_off  = f.frame_kind == KIND_COMMAND &&
              (f.what_code == CMD_ON || f.what_code == CMD_OFF);
    lvl     = int'(lamp_level);

    if (on_off && (cnt == 0 || (cnt == 1 && adv))) begin
      r.on_valid = 1'b1;
      r.on_value = f.what_code == CMD_ON;
    end
    if (f.what_code >= TIMED_ON_FIRST && f.what_code <= TIMED_ON_LAST) begin
      r.on_valid = 1'b1;
      r.on_value = 1'b1;
    end
    // A light switched on at an unknown level asks for its level later, unless
    // the frame was addressed to this device alone.
    if (r.on_valid) begin
      lamp_on = r.on_value;
      if (lamp_on && lvl == 0 && !f.point_to_point) r.start_query = 1'b1;
      else r.cancel_query = 1'b1;
      if (lamp_on && lvl != 0) begin
        r.ten_valid = 1'b1;
        r.ten_level = 4'(ten_step_of(lvl));
      end
    end

    if (f.frame_kind == KIND_COMMAND) begin
      if (f.what_code >= TEN_STEP_LOW && f.what_code <= TEN_STEP_HIGH) begin
        lvl = level_of_ten(int'(f.what_code));
        r.on_valid  = 1'b1;
        r.on_value  = 1'b1;
        r.ten_valid = 1'b1;
        r.ten_level = 4'(ten_step_of(lvl));
      end else if (f.what_code == cfg_fault) begin
        r.fault_seen = 1'b1;
      end
    end

    if (inc_dec && cnt == 0) begin
      if (lamp_on) begin
        tens = clamp(ten_step_of(lvl) + (f.what_code == CMD_STEP_UP ? 1 : -1),
                     int'(TEN_STEP_LOW), int'(TEN_STEP_HIGH));
        lvl = level_of_ten(tens);
        r.ten_level = 4'(tens);
      end else begin
        lamp_on = 1'b1;
        r.ten_level = 4'(ten_step_of(lvl));
      end
      r.ten_valid = 1'b1;
      r.on_valid  = 1'b1;
      r.on_value  = 1'b1;
    end

    if (inc_dec && cnt == 2 && adv) begin
      if (lamp_on) lvl = clamp(f.what_code == CMD_STEP_UP ? lvl + a1 : lvl - a1,
                               1, int'(LEVEL_MAX));
      else lamp_on = 1'b1;
      r.ten_valid = 1'b1;
      r.ten_level = 4'(ten_step_of(lvl));
      r.on_valid  = 1'b1;
      r.on_value  = 1'b1;
    end

    if (f.what_code == DIM_STATUS_CODE && is_dim && adv) begin
      if (a1 == int'(STATUS_OFFSET)) begin
        lamp_on    = 1'b0;
        r.on_valid = 1'b1;
        r.on_value = 1'b0;
      end else begin
        lvl = clamp(a1 - int'(STATUS_OFFSET), 0, int'(LEVEL_MAX));
        lamp_on     = 1'b1;
        r.on_valid  = 1'b1;
        r.on_value  = 1'b1;
        r.ten_valid = 1'b1;
        r.ten_level = 4'(ten_step_of(lvl));
      end
    end

    lamp_level = 7'(lvl);

    if (cfg_hso) begin
      if (r.ten_valid) begin
        r.hundred_valid = 1'b1;
        r.hundred_level = 7'(lvl);
      end
      if (on_off && cnt == 1) begin
        r.on_valid = 1'b1;
        r.on_value = f.what_code == CMD_ON;
      end
      if (f.what_code == DIM_STATUS_CODE && f.frame_kind == KIND_DIM_READ && lamp_on) begin
        r.speed_valid = 1'b1;
        r.ramp_speed  = f.arg_second;
      end
      if (inc_dec && cnt == 2) begin
        r.hundred_valid = 1'b1;
        r.hundred_level = 7'(lvl);
      end
    end
    return r;
  endfunction

  function automatic string show(input dlt_out_t r);
    return $sformatf("on %0b/%0b ten %0b/%0d hundred %0b/%0d speed %0b/%0d fault %0b start %0b cancel %0b",
                     r.on_valid, r.on_value, r.ten_valid, r.ten_level, r.hundred_valid,
                     r.hundred_level, r.speed_valid, r.ramp_speed, r.fault_seen,
                     r.start_query, r.cancel_query);
  endfunction

  function automatic dlt_in_t make_frame(input int kind, input int code, input int cnt,
                                         input int a1, input int a2, input int p2p);
    dlt_in_t f;
    f.frame_kind     = 2'(kind);
    f.what_code      = 6'(code);
    f.arg_count      = 2'(cnt);
    f.arg_first      = 8'(a1);
    f.arg_second     = 8'(a2);
    f.point_to_point = 1'(p2p);
    return f;
  endfunction

  // Mostly frames that the block acts on, with random arguments, plus some noise.
  function automatic dlt_in_t random_frame();
    dlt_in_t f;
    int      pick;
    f    = dlt_in_t'(IN_W'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 16) begin
      f.what_code = $urandom_range(0, 1) ? CMD_ON : CMD_OFF;
      if ($urandom_range(0, 9) != 0) f.frame_kind = KIND_COMMAND;
      if ($urandom_range(0, 7) != 0) f.arg_count = 2'($urandom_range(0, 1));
    end else if (pick < 30) begin
      f.what_code = 6'($urandom_range(TEN_STEP_LOW, TEN_STEP_HIGH));
      if ($urandom_range(0, 9) != 0) f.frame_kind = KIND_COMMAND;
    end else if (pick < 40) begin
      f.what_code = 6'($urandom_range(TIMED_ON_FIRST, TIMED_ON_LAST));
    end else if (pick < 62) begin
      f.what_code = $urandom_range(0, 1) ? CMD_STEP_UP : CMD_STEP_DOWN;
      if ($urandom_range(0, 3) != 0) f.frame_kind = KIND_COMMAND;
      if ($urandom_range(0, 7) != 0) f.arg_count = $urandom_range(0, 1) ? 2'd2 : 2'd0;
      if ($urandom_range(0, 3) != 0) f.arg_first = 8'($urandom_range(0, 40));
    end else if (pick < 80) begin
      f.what_code = DIM_STATUS_CODE;
      if ($urandom_range(0, 7) != 0)
        f.frame_kind = $urandom_range(0, 1) ? KIND_DIM_READ : KIND_DIM_WRITE;
      if ($urandom_range(0, 2) == 0) f.arg_first = 8'($urandom_range(95, 105));
    end else if (pick < 85) begin
      f.what_code  = cfg_fault;
      f.frame_kind = KIND_COMMAND;
    end
    return f;
  endfunction

  // Offers one frame and returns once its transfer has taken place.
  task automatic send_frame(input dlt_in_t f);
    int gap;
    gap = 0;
    if (!tx_steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 6);
    end
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      frame_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    frame_valid <= 1'b1;
    frame       <= f;
    do @(posedge clk); while (!frame_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    frame_valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_en    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ADVANCED_MODE:        cfg_adv = data[0];
      REG_HUNDRED_STEP_OUTPUTS: cfg_hso = data[0];
      REG_FAULT_CODE:           cfg_fault = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_en <= 1'b0;
  endtask

  // The upper bits of the one-bit registers carry random junk.
  task automatic set_config(input bit adv, input bit hso, input logic [5:0] fault);
    write_reg(REG_ADVANCED_MODE, {5'($urandom), adv});
    write_reg(REG_HUNDRED_STEP_OUTPUTS, {5'($urandom), hso});
    write_reg(REG_FAULT_CODE, fault);
    write_reg(REG_UNUSED, 6'($urandom));
  endtask

  // Reset configuration: ten-step frames only, fault on code 19.
  task automatic test_basic_commands();
    send_frame(make_frame(KIND_DIM_READ, DIM_STATUS_CODE, 2, 150, 7, 0));
    send_frame(make_frame(KIND_COMMAND, CMD_ON, 0, 0, 0, 0));
    send_frame(make_frame(KIND_COMMAND, CMD_OFF, 0, 255, 255, 0));
    send_frame(make_frame(KIND_COMMAND, CMD_ON, 0, 0, 0, 1));
    send_frame(make_frame(KIND_COMMAND, CMD_ON, 1, 0, 0, 0));
    send_frame(make_frame(KIND_COMMAND, TEN_STEP_HIGH, 0, 0, 0, 0));
    send_frame(make_frame(KIND_COMMAND, CMD_STEP_UP, 0, 0, 0, 0));
    send_frame(make_frame(KIND_COMMAND, TEN_STEP_LOW, 0, 0, 0, 0));
    send_frame(make_frame(KIND_COMMAND, CMD_STEP_DOWN, 0, 0, 0, 0));
    send_frame(make_frame(KIND_COMMAND, CMD_OFF, 0, 0, 0, 1));
    // A level command while off reports on but leaves the light off.
    send_frame(make_frame(KIND_COMMAND, 9, 0, 0, 0, 0));
    send_frame(make_frame(KIND_COMMAND, CMD_STEP_UP, 0, 0, 0, 0));
    send_frame(make_frame(KIND_OTHER, TIMED_ON_FIRST, 3, 0, 0, 0));
    send_frame(make_frame(KIND_DIM_WRITE, TIMED_ON_LAST, 0, 0, 0, 1));
    send_frame(make_frame(KIND_COMMAND, FAULT_CODE_RESET, 0, 0, 0, 0));
    send_frame(make_frame(KIND_OTHER, CMD_ON, 0, 0, 0, 0));
    send_frame(make_frame(KIND_OTHER, CMD_STEP_DOWN, 0, 0, 0, 0));
    drain();
  endtask

  // Hundred-step outputs on, which implies the advanced frames.
  task automatic test_hundred_step();
    set_config(1'b0, 1'b1, 6'd5);
    send_frame(make_frame(KIND_COMMAND, 5, 0, 0, 0, 0));
    send_frame(make_frame(KIND_DIM_READ, DIM_STATUS_CODE, 1, 100, 9, 0));
    send_frame(make_frame(KIND_COMMAND, CMD_ON, 1, 0, 0, 0));
    send_frame(make_frame(KIND_DIM_READ, DIM_STATUS_CODE, 3, 99, 255, 0));
    send_frame(make_frame(KIND_COMMAND, CMD_ON, 0, 0, 0, 0));
    send_frame(make_frame(KIND_COMMAND, CMD_STEP_DOWN, 0, 0, 0, 0));
    send_frame(make_frame(KIND_COMMAND, CMD_STEP_UP, 2, 255, 0, 0));
    send_frame(make_frame(KIND_OTHER, CMD_STEP_DOWN, 2, 255, 0, 0));
    send_frame(make_frame(KIND_DIM_WRITE, DIM_STATUS_CODE, 0, 255, 0, 0));
    send_frame(make_frame(KIND_DIM_READ, DIM_STATUS_CODE, 2, 0, 170, 1));
    drain();
  endtask

  // The receiver holds off for a long stretch while frames keep coming.
  task automatic test_result_backpressure();
    hold_requests++;
    tx_steady = 1'b1;
    repeat (40) send_frame(random_frame());
    tx_steady = 1'b0;
    drain();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      rx_steady = phase == 5;
      tx_steady = phase == 5;
      case (phase)
        0:       set_config(1'b1, 1'b0, 6'd0);
        1:       set_config(1'b0, 1'b1, 6'd63);
        2:       set_config(1'b1, 1'b1, 6'($urandom_range(TEN_STEP_LOW, TEN_STEP_HIGH)));
        3:       set_config(1'b0, 1'b0, CMD_ON);
        4:       set_config(1'($urandom), 1'($urandom), 6'($urandom));
        default: set_config(1'b1, 1'b1, TIMED_ON_FIRST);
      endcase
      repeat (PHASE_ITEMS) send_frame(random_frame());
      drain();
    end
    rx_steady = 1'b0;
    tx_steady = 1'b0;
  endtask

  // Receiver: runs of ready broken by short stalls, with a long hold on request.
  initial begin
    int run_left;
    int hold_left;
    int served;
    result_ready = 1'b0;
    run_left  = 0;
    hold_left = 0;
    served    = 0;
    forever begin
      @(negedge clk);
      if (served != hold_requests) begin
        served++;
        hold_left = LONG_HOLD;
        run_left  = 0;
      end else if (rx_steady) begin
        hold_left = 0;
        run_left  = 1;
      end else if (hold_left == 0 && run_left == 0) begin
        hold_left = $urandom_range(0, 5);
        run_left  = $urandom_range(1, 16);
      end
      if (hold_left > 0) begin
        result_ready <= 1'b0;
        hold_left--;
      end else begin
        result_ready <= 1'b1;
        run_left--;
      end
    end
  end

  // Checks each result transfer, then predicts from each frame transfer.
  always @(posedge clk) begin
    dlt_out_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result: %s", show(result));
        end else begin
          want = expected_results.pop_front();
          if (result !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result mismatch: expected %s, got %s", show(want), show(result));
          end
        end
      end
      if (frame_valid && frame_ready) expected_results.push_back(track_frame(frame));
    end
  end

  always @(posedge clk) begin
    if (rst || (frame_valid && frame_ready) || (result_valid && result_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    frame_valid   = 1'b0;
    frame         = '0;
    cfg_en        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    cfg_adv       = 1'b0;
    cfg_hso       = 1'b0;
    cfg_fault     = FAULT_CODE_RESET;
    lamp_on       = 1'b0;
    lamp_level    = '0;
    mismatches    = 0;
    quiet_cycles  = 0;
    burst_left    = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    hold_requests = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_basic_commands();
    test_hundred_step();
    test_result_backpressure();
    test_random_traffic();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- dimmer_level_tracker.f -----
+incdir+rtl
rtl/dlt_pkg.sv
rtl/dlt_update.sv
rtl/dimmer_level_tracker.sv
dv/dimmer_level_tracker_tb.sv
